// ===== src/sofpm_pkg.sv =====
package sofpm_pkg;

	// Ring geometry
	localparam int unsigned RING_DEPTH = 32768;
	localparam int unsigned PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);

	// Front-to-back queue
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Meter
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned LEVEL_W     = 8;
	localparam int unsigned FILL_W      = 16;
	localparam int unsigned LEVEL_SHIFT = 7;      // peak / 128
	localparam logic [SAMPLE_W-1:0] PEAK_MAX  = 16'd32767;
	localparam logic [LEVEL_W-1:0]  LEVEL_SAT = 8'd255;

	// Function codes on the input
	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_POP   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_CLEAR,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		logic [1:0]                 func;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       chunk_last;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       sample_valid;
		logic [LEVEL_W-1:0]         level;
		logic [FILL_W-1:0]          fill_count;
	} out_item_t;

	// Classified operation passed from front to back
	typedef struct packed {
		op_kind_t            kind;
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] mag;
		logic                last;
	} op_t;

endpackage

// ===== src/sofpm_front.sv =====
module sofpm_front (
	input  sofpm_pkg::in_item_t item,
	output sofpm_pkg::op_t      op
);
	import sofpm_pkg::*;

	logic [SAMPLE_W-1:0] raw;

	assign raw = item.sample_in;

	always_comb begin
		op.sample = raw;
		// two's complement magnitude; -32768 gives 0x8000
		op.mag    = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
		op.last   = 1'b0;
		unique case (item.func)
			FUNC_PUSH: begin
				op.kind = OP_PUSH;
				op.last = item.chunk_last;
			end
			FUNC_POP:   op.kind = OP_POP;
			FUNC_CLEAR: op.kind = OP_CLEAR;
			default:    op.kind = OP_NOP;
		endcase
	end

endmodule

// ===== src/sofpm_queue.sv =====
module sofpm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  sofpm_pkg::op_t  wr_op,
	output logic            rd_valid,
	input  logic            rd_ready,
	output sofpm_pkg::op_t  rd_op
);
	import sofpm_pkg::*;

	op_t               entry_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0] wr_idx_q;
	logic [QIDX_W-1:0] rd_idx_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op    = entry_q[rd_idx_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	function automatic logic [QIDX_W-1:0] idx_next(input logic [QIDX_W-1:0] i);
		return (i == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_idx_q <= idx_next(wr_idx_q);
			if (do_rd) rd_idx_q <= idx_next(rd_idx_q);
			if (do_wr && !do_rd)      count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_idx_q] <= wr_op;
	end

endmodule

// ===== src/sofpm_back.sv =====
module sofpm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 capture_enable,
	input  logic                 op_valid,
	output logic                 op_ready,
	input  sofpm_pkg::op_t       op,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sofpm_pkg::out_item_t out_item
);
	import sofpm_pkg::*;

	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;

	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    held_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [LEVEL_W-1:0]  level_q;

	logic                valid_s2;
	logic                hit_s2;

	logic                issue;
	logic                do_push;
	logic                do_pop;
	logic                full;
	logic [SAMPLE_W-1:0] peak_max;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign issue    = op_valid && (!valid_s2 || out_ready);
	assign op_ready = issue;
	assign do_push  = issue && (op.kind == OP_PUSH);
	assign do_pop   = issue && (op.kind == OP_POP) && capture_enable && (held_q != '0);
	assign full     = (held_q == CNT_W'(RING_DEPTH));
	assign peak_max = (op.mag > peak_q) ? op.mag : peak_q;

	// ring state and meter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			held_q   <= '0;
			peak_q   <= '0;
			level_q  <= '0;
		end else if (issue) begin
			case (op.kind)
				OP_PUSH: begin
					wr_ptr_q <= ptr_next(wr_ptr_q);
					if (full) rd_ptr_q <= ptr_next(rd_ptr_q);   // drop oldest
					else      held_q   <= held_q + 1'b1;
					if (op.last) begin
						level_q <= (peak_max > PEAK_MAX) ? LEVEL_SAT
							: peak_max[LEVEL_SHIFT +: LEVEL_W];
						peak_q  <= '0;
					end else begin
						peak_q  <= peak_max;
					end
				end
				OP_POP: begin
					if (do_pop) begin
						rd_ptr_q <= ptr_next(rd_ptr_q);
						held_q   <= held_q - 1'b1;
					end
				end
				OP_CLEAR: begin
					wr_ptr_q <= '0;
					rd_ptr_q <= '0;
					held_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (do_push) ring_mem[wr_ptr_q] <= op.sample;
	end

	always_ff @(posedge clk) begin
		if (do_pop) rd_data_q <= ring_mem[rd_ptr_q];
	end

	// result stage; level and count regs hold while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (issue) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) hit_s2 <= do_pop;
	end

	assign out_valid             = valid_s2;
	assign out_item.sample_out   = hit_s2 ? rd_data_q : '0;
	assign out_item.sample_valid = hit_s2;
	assign out_item.level        = level_q;
	assign out_item.fill_count   = FILL_W'(held_q);

endmodule

// ===== src/overwrite_sample_fifo_with_peak_meter.sv =====
// Items pass the op queue and back end to a registered result. Throughput:
// one item per cycle while out_ready is high; the single-port ring memory does
// one access per item and the two-entry op queue absorbs output stalls.
// Reset (arst_n low, async): pointers, fill count, chunk peak, level and
// capture_enable go to zero; ring contents are not cleared and are only read
// after being written.
module overwrite_sample_fifo_with_peak_meter (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items: push / pop / clear
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sofpm_pkg::in_item_t  in_data,
	// one result item per input item
	output logic                 out_valid,
	input  logic                 out_ready,
	output sofpm_pkg::out_item_t out_data,
	// capture_enable register
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data
);
	import sofpm_pkg::*;

	op_t  front_op;
	op_t  back_op;
	logic back_valid;
	logic back_ready;
	logic capture_enable_q;

	// Config register; the user must write it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			capture_enable_q <= cfg_wr_data;
		end
	end

	// Front: decode func code and precompute sample magnitude.
	sofpm_front u_front (
		.item (in_data),
		.op   (front_op)
	);

	// Short queue decouples input acceptance from ring execution.
	// in_ready depends only on queue occupancy, never on out_ready.
	sofpm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_ready (in_ready),
		.wr_op    (front_op),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_op    (back_op)
	);

	// Back: ring pointers, memory, peak meter and result register.
	// An op issues when the result register is free or being drained.
	sofpm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.capture_enable (capture_enable_q),
		.op_valid       (back_valid),
		.op_ready       (back_ready),
		.op             (back_op),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_data)
	);

endmodule
